// ===== rtl/lqs_pkg.sv =====
// Package with the shared types and constants of the linear queue with search.
package lqs_pkg;

	// Fixed widths of the beat fields.
	localparam int VAL_W = 32;
	localparam int POS_W = 7;
	localparam int IDX_W = 7;
	localparam int OP_W  = 2;
	localparam int ST_W  = 3;

	// Operation codes carried by an input beat.
	typedef enum logic [OP_W-1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_MOD  = 2'd2,
		OP_SRCH = 2'd3
	} op_t;

	// Status codes carried by a result beat.
	typedef enum logic [ST_W-1:0] {
		STS_OK       = 3'd0,
		STS_FULL     = 3'd1,
		STS_EMPTY    = 3'd2,
		STS_BADPOS   = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ_WAIT,
		S_SRCH_RD,
		S_SRCH_CMP
	} state_t;

	// Word returned by a dequeue from an empty queue.
	localparam logic [VAL_W-1:0] EMPTY_WORD = '1;

endpackage

// ===== rtl/linear_queue_with_search_core.sv =====
// Linear array queue of 32-bit words with enqueue, dequeue, modify and search.
// Enqueue, modify, full, empty and bad-position results go straight to the output register;
// a dequeue of a stored word first reads the slot memory into rd_data_q, then loads it.
// A search reads and then compares one slot at a time from the head until a hit or the tail;
// one read port and one comparator are reused for every slot. A new beat is taken only while
// the sequencer is idle and the output is free; a dequeue or search holds off later beats.
// Reset clears the pointers, the sequencer and the output valid at once; memory is not cleared.
module linear_queue_with_search_core
	import lqs_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [OP_W-1:0]  op,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0] position,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [ST_W-1:0]  status,
	output logic signed [VAL_W-1:0] value_out,
	output logic [IDX_W-1:0] index_out
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(DEPTH + 1);
	localparam int CW = (PW > POS_W) ? PW : POS_W;
	localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

	state_t state_q, state_d;

	logic [PW-1:0]    head_q, tail_q, idx_q;
	logic [VAL_W-1:0] key_q;
	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [VAL_W-1:0] out_value_q;
	logic [IDX_W-1:0] out_index_q;

	logic             out_free, accept;
	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic             head_inc, tail_inc, idx_load, idx_inc;
	logic             out_load;
	status_t          res_status;
	logic [VAL_W-1:0] res_value;
	logic [IDX_W-1:0] res_index;

	logic [CW-1:0]    pos_ext, tail_ext, idx_ext;
	logic             is_full, is_empty, pos_bad, idx_end, key_hit;

	// Handshake on the input side.
	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;

	// Shared conditions and the single comparator.
	assign pos_ext  = CW'(position);
	assign tail_ext = CW'(tail_q);
	assign idx_ext  = CW'(idx_q);
	assign is_full  = (tail_q == DEPTH_P);
	assign is_empty = (head_q == tail_q);
	assign pos_bad  = (pos_ext >= tail_ext);
	assign idx_end  = (idx_q >= tail_q);
	assign key_hit  = (rd_data_q == key_q);

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_DEQ:  state_d = is_empty ? S_IDLE : S_DEQ_WAIT;
						OP_SRCH: state_d = S_SRCH_RD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_DEQ_WAIT: begin
				if (out_free) state_d = S_IDLE;
			end
			S_SRCH_RD: begin
				if (!idx_end) state_d = S_SRCH_CMP;
				else if (out_free) state_d = S_IDLE;
			end
			S_SRCH_CMP: begin
				if (!key_hit) state_d = S_SRCH_RD;
				else if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: memory ports, pointer steps and the result to load.
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = head_q[AW-1:0];
		wr_en      = 1'b0;
		wr_addr    = tail_q[AW-1:0];
		head_inc   = 1'b0;
		tail_inc   = 1'b0;
		idx_load   = 1'b0;
		idx_inc    = 1'b0;
		out_load   = 1'b0;
		res_status = STS_OK;
		res_value  = '0;
		res_index  = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_ENQ: begin
							out_load = 1'b1;
							if (is_full) begin
								res_status = STS_FULL;
							end else begin
								wr_en    = 1'b1;
								tail_inc = 1'b1;
							end
						end
						OP_DEQ: begin
							if (is_empty) begin
								out_load   = 1'b1;
								res_status = STS_EMPTY;
								res_value  = EMPTY_WORD;
							end else begin
								rd_en    = 1'b1;
								head_inc = 1'b1;
							end
						end
						OP_MOD: begin
							out_load = 1'b1;
							if (pos_bad) begin
								res_status = STS_BADPOS;
							end else begin
								wr_en   = 1'b1;
								wr_addr = pos_ext[AW-1:0];
							end
						end
						OP_SRCH: idx_load = 1'b1;
						default: ;
					endcase
				end
			end
			S_DEQ_WAIT: begin
				out_load  = out_free;
				res_value = rd_data_q;
			end
			S_SRCH_RD: begin
				if (!idx_end) begin
					rd_en   = 1'b1;
					rd_addr = idx_q[AW-1:0];
				end else begin
					out_load   = out_free;
					res_status = STS_NOTFOUND;
				end
			end
			S_SRCH_CMP: begin
				if (key_hit) begin
					out_load  = out_free;
					res_index = idx_ext[IDX_W-1:0];
				end else begin
					idx_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer state and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			if (head_inc) head_q <= head_q + 1'b1;
			if (tail_inc) tail_q <= tail_q + 1'b1;
		end
	end

	// Search index and key.
	always_ff @(posedge clk) begin
		if (idx_load) begin
			idx_q <= head_q;
			key_q <= value;
		end else if (idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Slot memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= value;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// Output register: holds a result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status;
			out_value_q  <= res_value;
			out_index_q  <= res_index;
		end
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_status_q;
	assign value_out = out_value_q;
	assign index_out = out_index_q;

	// The head never passes the tail.
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("head pointer passed tail pointer");

	// The tail never runs past the capacity.
	a_tail_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= DEPTH_P)
		else $error("tail pointer beyond capacity");

	// A waiting result beat is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_stall) |-> !out_load)
		else $error("pending result overwritten");

	// A compare step always follows a read step or another stalled compare.
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH_CMP) |-> ($past(state_q) == S_SRCH_RD ||
			$past(state_q) == S_SRCH_CMP))
		else $error("compare step without a slot read");

	// A dequeue of a stored word waits for the memory read.
	a_deq_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && head_inc) |=> (state_q == S_DEQ_WAIT))
		else $error("dequeue did not wait for read data");

endmodule

// ===== dv/linear_queue_with_search_core_test.sv =====
// Self-checking testbench for the linear queue with search: random traffic, idling and a predictor.
module linear_queue_with_search_core_test;
	import lqs_pkg::*;

	localparam int QUEUE_DEPTH = 128;
	localparam int RANDOM_BEATS = 1450;
	localparam int PLAN = 0;
	localparam int LIVE = 1;

	typedef struct packed {
		status_t         status;
		logic [VAL_W-1:0] word;
		logic [IDX_W-1:0] index;
	} queue_result_t;

	typedef struct {
		op_t              kind;
		logic [VAL_W-1:0] word;
		logic [POS_W-1:0] slot;
		bit               hold;
	} queue_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [OP_W-1:0] op = OP_ENQ;
	logic signed [VAL_W-1:0] value = '0;
	logic [POS_W-1:0] position = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [ST_W-1:0] status;
	logic signed [VAL_W-1:0] value_out;
	logic [IDX_W-1:0] index_out;

	// Two copies of the queue contents: one used while planning stimulus, one for checking.
	logic [VAL_W-1:0] slots [2][QUEUE_DEPTH];
	logic [7:0] head_ptr [2];
	logic [7:0] tail_ptr [2];

	queue_beat_t beats_pending[$];
	queue_result_t results_due[$];
	queue_beat_t next_beat;
	queue_result_t fresh_result;
	queue_result_t oldest_result;
	logic req_fire = 1'b0;
	int gap_left = 0;
	int send_calm = 0;
	int stall_left = 0;
	int rcv_calm = 0;
	int error_count = 0;
	int results_checked = 0;
	int search_hits = 0;
	int beats_by_op [4] = '{0, 0, 0, 0};

	linear_queue_with_search_core #(
		.DEPTH(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.op(op),
		.value(value),
		.position(position),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.value_out(value_out),
		.index_out(index_out)
	);

	always #10 clk = ~clk;

	// Apply one operation to a copy of the queue and return the result it produces.
	function automatic queue_result_t queue_apply(int which, op_t kind, logic [VAL_W-1:0] word,
			logic [POS_W-1:0] slot);
		queue_result_t res;
		int k;
		bit found;
		res.status = STS_OK;
		res.word = '0;
		res.index = '0;
		found = 1'b0;
		case (kind)
			OP_ENQ: begin
				if (tail_ptr[which] >= QUEUE_DEPTH) begin
					res.status = STS_FULL;
				end else begin
					slots[which][tail_ptr[which]] = word;
					tail_ptr[which] = tail_ptr[which] + 8'd1;
				end
			end
			OP_DEQ: begin
				if (head_ptr[which] >= tail_ptr[which]) begin
					res.status = STS_EMPTY;
					res.word = EMPTY_WORD;
				end else begin
					res.word = slots[which][head_ptr[which]];
					head_ptr[which] = head_ptr[which] + 8'd1;
				end
			end
			OP_MOD: begin
				if ({1'b0, slot} >= tail_ptr[which]) begin
					res.status = STS_BADPOS;
				end else begin
					slots[which][slot] = word;
				end
			end
			default: begin
				// Scan from head to tail and stop at the first slot that matches.
				for (k = head_ptr[which]; k < tail_ptr[which] && !found; k++) begin
					if (slots[which][k] == word) begin
						found = 1'b1;
						res.index = k[IDX_W-1:0];
					end
				end
				if (!found) begin
					res.status = STS_NOTFOUND;
				end
			end
		endcase
		return res;
	endfunction

	// Idle stretch: usually a short one, now and then a long one.
	function automatic int idle_length();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(40, 12);
		end
		return $urandom_range(3, 1);
	endfunction

	// Words from a small pool make duplicates likely, so first-match order gets exercised.
	function automatic logic [VAL_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4: return 32'h0000_0005;
			default: return $urandom;
		endcase
	endfunction

	// Queue one beat for the driver and advance the planning copy with it.
	task automatic plan_beat(op_t kind, logic [VAL_W-1:0] word, logic [POS_W-1:0] slot, bit hold);
		queue_beat_t b;
		b.kind = kind;
		b.word = word;
		b.slot = slot;
		b.hold = hold;
		void'(queue_apply(PLAN, kind, word, slot));
		beats_pending.push_back(b);
	endtask

	// Pick a search key: mostly a live word, sometimes one already dequeued, else anything.
	function automatic logic [VAL_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 60 && tail_ptr[PLAN] > head_ptr[PLAN]) begin
			return slots[PLAN][$urandom_range(tail_ptr[PLAN] - 1, head_ptr[PLAN])];
		end
		if (r < 75 && head_ptr[PLAN] > 0) begin
			return slots[PLAN][$urandom_range(head_ptr[PLAN] - 1, 0)];
		end
		return pick_word();
	endfunction

	// Request driver: presents the next beat after a random gap, or holds it until idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (beats_pending.size() != 0 &&
					!(beats_pending[0].hold && results_due.size() != 0)) begin
				next_beat = beats_pending.pop_front();
				req_valid <= 1'b1;
				op <= next_beat.kind;
				value <= next_beat.word;
				position <= next_beat.slot;
				if (send_calm > 0) begin
					send_calm--;
					gap_left = 0;
				end else if ($urandom_range(19) == 0) begin
					send_calm = $urandom_range(60, 20);
					gap_left = 0;
				end else begin
					gap_left = ($urandom_range(1) == 0) ? 0 : idle_length();
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response stall: random stalls with quiet stretches in between.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
			if (rcv_calm > 0) begin
				rcv_calm--;
			end else if ($urandom_range(29) == 0) begin
				rcv_calm = $urandom_range(80, 20);
			end else if ($urandom_range(2) == 0) begin
				stall_left = idle_length();
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		error_count++;
		if (error_count <= 50) begin
			$display("%0t: %s differs, got %h, expected %h", $time, what, got, want);
		end
	endtask

	// Monitor: predicts each accepted request beat and checks each accepted response beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_fire <= 1'b0;
		end else begin
			req_fire <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				fresh_result = queue_apply(LIVE, op_t'(op), value, position);
				results_due.push_back(fresh_result);
				beats_by_op[op]++;
				if (op_t'(op) == OP_SRCH && fresh_result.status == STS_OK) begin
					search_hits++;
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with nothing outstanding, status", status, '0);
				end else begin
					oldest_result = results_due.pop_front();
					results_checked++;
					if (status !== oldest_result.status) begin
						report_mismatch("status", status, oldest_result.status);
					end
					if (value_out !== oldest_result.word) begin
						report_mismatch("value_out", value_out, oldest_result.word);
					end
					if (index_out !== oldest_result.index) begin
						report_mismatch("index_out", index_out, oldest_result.index);
					end
				end
			end
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin
		int n;
		int r;
		head_ptr[PLAN] = '0;
		tail_ptr[PLAN] = '0;
		head_ptr[LIVE] = '0;
		tail_ptr[LIVE] = '0;

		// Directed: empty queue, value extremes, duplicates, dequeued slots, bad positions.
		plan_beat(OP_DEQ, 32'h0000_0000, 7'd0, 1'b0);
		plan_beat(OP_SRCH, 32'h0000_0000, 7'd127, 1'b0);
		plan_beat(OP_MOD, 32'h1111_1111, 7'd0, 1'b0);
		plan_beat(OP_MOD, 32'h2222_2222, 7'd127, 1'b0);
		plan_beat(OP_ENQ, 32'h8000_0000, 7'd0, 1'b0);
		plan_beat(OP_ENQ, 32'h7FFF_FFFF, 7'd127, 1'b0);
		plan_beat(OP_ENQ, 32'hFFFF_FFFF, 7'd0, 1'b0);
		plan_beat(OP_ENQ, 32'h0000_0000, 7'd0, 1'b0);
		plan_beat(OP_ENQ, 32'h7FFF_FFFF, 7'd0, 1'b0);
		plan_beat(OP_SRCH, 32'h7FFF_FFFF, 7'd0, 1'b0);
		plan_beat(OP_SRCH, 32'h1234_5678, 7'd0, 1'b0);
		plan_beat(OP_MOD, 32'h3333_3333, 7'd5, 1'b0);
		plan_beat(OP_MOD, 32'h5555_5555, 7'd4, 1'b0);
		plan_beat(OP_MOD, 32'h4444_4444, 7'd42, 1'b0);
		plan_beat(OP_DEQ, 32'hFFFF_FFFF, 7'd127, 1'b0);
		plan_beat(OP_SRCH, 32'h8000_0000, 7'd0, 1'b0);
		plan_beat(OP_MOD, 32'hAAAA_AAAA, 7'd0, 1'b0);
		plan_beat(OP_SRCH, 32'hAAAA_AAAA, 7'd0, 1'b0);
		plan_beat(OP_SRCH, 32'h5555_5555, 7'd0, 1'b0);
		plan_beat(OP_DEQ, 32'h0000_0000, 7'd0, 1'b0);
		plan_beat(OP_SRCH, 32'h7FFF_FFFF, 7'd0, 1'b0);

		// Random traffic; enqueues are rationed so the queue fills only late in the run.
		for (n = 0; n < RANDOM_BEATS; n++) begin
			r = $urandom_range(99);
			if (r < 12) begin
				plan_beat(OP_ENQ, pick_word(), POS_W'($urandom), n % 350 == 0);
			end else if (r < 20) begin
				plan_beat(OP_DEQ, $urandom, POS_W'($urandom), n % 350 == 0);
			end else if (r < 55) begin
				if ($urandom_range(4) != 0 && tail_ptr[PLAN] != 0) begin
					plan_beat(OP_MOD, pick_word(), POS_W'($urandom_range(tail_ptr[PLAN] - 1)),
						n % 350 == 0);
				end else begin
					plan_beat(OP_MOD, pick_word(), POS_W'($urandom), n % 350 == 0);
				end
			end else begin
				plan_beat(OP_SRCH, pick_key(), POS_W'($urandom), n % 350 == 0);
			end
		end

		// Fill to capacity, hit the full case, find the last slot, then drain past empty.
		plan_beat(OP_SRCH, pick_key(), 7'd0, 1'b1);
		while (tail_ptr[PLAN] < QUEUE_DEPTH) begin
			plan_beat(OP_ENQ, $urandom, 7'd0, 1'b0);
		end
		plan_beat(OP_ENQ, 32'h0BAD_F00D, 7'd0, 1'b0);
		plan_beat(OP_ENQ, 32'h0BAD_F00D, 7'd127, 1'b0);
		plan_beat(OP_MOD, 32'h5A5A_C3C3, 7'd127, 1'b0);
		plan_beat(OP_SRCH, 32'h5A5A_C3C3, 7'd0, 1'b0);
		while (head_ptr[PLAN] < tail_ptr[PLAN]) begin
			plan_beat(OP_DEQ, 32'h0000_0000, 7'd0, 1'b0);
		end
		plan_beat(OP_DEQ, 32'h0000_0000, 7'd0, 1'b0);
		plan_beat(OP_SRCH, 32'h5A5A_C3C3, 7'd0, 1'b0);
		plan_beat(OP_MOD, 32'hCAFE_0000, 7'd0, 1'b0);
		plan_beat(OP_ENQ, 32'h0000_0001, 7'd0, 1'b0);

		// Hold reset, then release it on a falling edge.
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		while (beats_pending.size() != 0 || req_valid || results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (300) @(posedge clk);

		$display("Checked %0d results from %0d enqueue, %0d dequeue, %0d modify and %0d search beats.",
			results_checked, beats_by_op[OP_ENQ], beats_by_op[OP_DEQ], beats_by_op[OP_MOD],
			beats_by_op[OP_SRCH]);
		$display("The queue went from empty to full and back; %0d searches found their key.",
			search_hits);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
